>>> rtl/core/uart_rx_tx_ring_buffers_defines.svh
// assertion macros for the uart ring buffer block
// used by the top level only; expects clk and rst_n in scope
`ifndef UART_RX_TX_RING_BUFFERS_DEFINES_SVH
`define UART_RX_TX_RING_BUFFERS_DEFINES_SVH

// check that is switched off while reset is applied
`define UARTRB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is applied
`define UARTRB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/uartrb_pkg.sv
// shared types and constants for the uart ring buffer block
// no dependencies
package uartrb_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int FUNC_W         = 3;
    localparam int BYTE_W         = 8;

    // event codes on func
    localparam logic [FUNC_W-1:0] FUNC_HOST_WRITE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_HOST_READ  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_LINE_RX    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TX_EMPTY   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH_RX   = 3'd4;

    typedef enum logic
    {
        ST_IDLE,
        ST_FETCH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed
    {
        logic take;   // input transaction taken this cycle
        logic fill;   // ram read data lands in the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic pop;    // decoded event reads a ring entry
    } dp_status_t;

endpackage

>>> rtl/core/uartrb_ram.sv
// generic single write port ram with registered read
// no dependencies
module uartrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/uartrb_ctrl.sv
// controller for the uart ring buffer block: handshake and read sequencing
// depends on uartrb_pkg
module uartrb_ctrl
    import uartrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_blocked;

    assign out_blocked = out_valid_reg && out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !out_blocked && status.pop)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        in_stall = 1'b1;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = out_blocked;
                cmd.take = in_valid && !out_blocked;
            end
            ST_FETCH:
            begin
                cmd.fill = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((cmd.take && !status.pop) || cmd.fill)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/uartrb_dp.sv
// datapath for the uart ring buffer block: ring indices, stores, result register
// depends on uartrb_pkg and uartrb_ram
module uartrb_dp
    import uartrb_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic [FUNC_W-1:0] func,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              frame_error,
    output logic              write_accepted,
    output logic [BYTE_W-1:0] read_byte,
    output logic              rx_was_empty,
    output logic [BYTE_W-1:0] line_byte,
    output logic              line_byte_valid,
    output logic              tx_irq_enable,
    output logic              tx_pending
);

    localparam int              IDX_W    = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    logic [IDX_W-1:0] rx_head_reg, rx_head_next;
    logic [IDX_W-1:0] rx_tail_reg, rx_tail_next;
    logic [IDX_W-1:0] tx_head_reg, tx_head_next;
    logic [IDX_W-1:0] tx_tail_reg, tx_tail_next;
    logic             irq_reg, irq_next;

    logic             rx_full, rx_empty, tx_full, tx_empty;
    logic             rx_push, rx_pop, tx_push, tx_pop;
    logic             dec_accepted, dec_was_empty;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;

    logic             write_accepted_reg;
    logic [BYTE_W-1:0] read_byte_reg;
    logic             rx_was_empty_reg;
    logic [BYTE_W-1:0] line_byte_reg;
    logic             line_byte_valid_reg;
    logic             tx_irq_enable_reg;
    logic             tx_pending_reg;
    logic             fill_rx_reg;

    // ring occupancy
    assign rx_empty = (rx_head_reg == rx_tail_reg);
    assign tx_empty = (tx_head_reg == tx_tail_reg);
    assign rx_full  = (ring_next(rx_head_reg) == rx_tail_reg);
    assign tx_full  = (ring_next(tx_head_reg) == tx_tail_reg);

    // event decode
    always_comb
    begin
        rx_push       = 1'b0;
        rx_pop        = 1'b0;
        tx_push       = 1'b0;
        tx_pop        = 1'b0;
        dec_accepted  = 1'b0;
        dec_was_empty = 1'b0;
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        irq_next      = irq_reg;
        case (func)
            FUNC_HOST_WRITE:
            begin
                if (!tx_full)
                begin
                    tx_push      = 1'b1;
                    tx_head_next = ring_next(tx_head_reg);
                    dec_accepted = 1'b1;
                    irq_next     = 1'b1;
                end
            end
            FUNC_HOST_READ:
            begin
                if (rx_empty)
                begin
                    dec_was_empty = 1'b1;
                end
                else
                begin
                    rx_pop       = 1'b1;
                    rx_tail_next = ring_next(rx_tail_reg);
                end
            end
            FUNC_LINE_RX:
            begin
                if (!frame_error && !rx_full)
                begin
                    rx_push      = 1'b1;
                    rx_head_next = ring_next(rx_head_reg);
                end
            end
            FUNC_TX_EMPTY:
            begin
                if (!tx_empty)
                begin
                    tx_pop       = 1'b1;
                    tx_tail_next = ring_next(tx_tail_reg);
                end
                else
                begin
                    irq_next = 1'b0;
                end
            end
            FUNC_FLUSH_RX:
            begin
                rx_head_next = '0;
                rx_tail_next = '0;
            end
            default:
            begin
                irq_next = irq_reg;
            end
        endcase
    end

    assign status.pop = rx_pop || tx_pop;

    // ring index and interrupt enable registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            irq_reg     <= 1'b0;
        end
        else if (cmd.take)
        begin
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            irq_reg     <= irq_next;
        end
    end

    // byte stores, read at the tail and written at the head
    uartrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (cmd.take && rx_push),
        .waddr (rx_head_reg),
        .wdata (data_byte),
        .re    (cmd.take),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    uartrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (cmd.take && tx_push),
        .waddr (tx_head_reg),
        .wdata (data_byte),
        .re    (cmd.take),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    // result register, popped byte merged in the cycle after the event is taken
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            write_accepted_reg  <= dec_accepted;
            read_byte_reg       <= '0;
            rx_was_empty_reg    <= dec_was_empty;
            line_byte_reg       <= '0;
            line_byte_valid_reg <= tx_pop;
            tx_irq_enable_reg   <= irq_next;
            tx_pending_reg      <= (tx_head_next != tx_tail_next);
            fill_rx_reg         <= rx_pop;
        end
        else if (cmd.fill)
        begin
            if (fill_rx_reg)
            begin
                read_byte_reg <= rx_rdata;
            end
            else
            begin
                line_byte_reg <= tx_rdata;
            end
        end
    end

    assign write_accepted  = write_accepted_reg;
    assign read_byte       = read_byte_reg;
    assign rx_was_empty    = rx_was_empty_reg;
    assign line_byte       = line_byte_reg;
    assign line_byte_valid = line_byte_valid_reg;
    assign tx_irq_enable   = tx_irq_enable_reg;
    assign tx_pending      = tx_pending_reg;

endmodule

>>> rtl/core/uart_rx_tx_ring_buffers.sv
// top level of the uart ring buffer block: controller plus datapath
// depends on uartrb_pkg, uartrb_ctrl, uartrb_dp and the assertion macro header
//
// usage: each input transaction (func, data_byte, frame_error) is one event:
// host write, host read, line byte received, transmitter empty or receive flush.
// every event yields exactly one result transaction on the output channel.
// both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// timing: an event that pops no ring entry shows its result the cycle after
// it is taken; a host read or transmitter-empty event that pops a byte also
// passes through the fetch state, which waits on the registered store read.
// throughput: one event per cycle without a pop, if not stalled; a popping event
// stalls the input until its byte is fetched. the input side is taken while a
// result waits, as long as the output register is free or drains in that same
// cycle; a stalled result holds and stops further input until it is taken.
// reset clears both rings, the interrupt enable and the result valid flag;
// no clearing pass is needed, the block takes events right after reset.
`include "uart_rx_tx_ring_buffers_defines.svh"

module uart_rx_tx_ring_buffers
    import uartrb_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              frame_error,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              write_accepted,
    output logic [BYTE_W-1:0] read_byte,
    output logic              rx_was_empty,
    output logic [BYTE_W-1:0] line_byte,
    output logic              line_byte_valid,
    output logic              tx_irq_enable,
    output logic              tx_pending
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    uartrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // rings and result register
    uartrb_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .func            (func),
        .data_byte       (data_byte),
        .frame_error     (frame_error),
        .write_accepted  (write_accepted),
        .read_byte       (read_byte),
        .rx_was_empty    (rx_was_empty),
        .line_byte       (line_byte),
        .line_byte_valid (line_byte_valid),
        .tx_irq_enable   (tx_irq_enable),
        .tx_pending      (tx_pending)
    );

    // checks
    `UARTRB_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !out_valid, "result valid during reset")
    `UARTRB_ASSERT(a_pop_result_next, (cmd.take && status.pop) |=> (cmd.fill && !out_valid), "pop sequencing broken")
    `UARTRB_ASSERT(a_fill_stalls_input, cmd.fill |-> (in_stall && !cmd.take), "input taken during store read")
    `UARTRB_ASSERT(a_write_sets_irq, (out_valid && write_accepted) |-> (tx_pending && tx_irq_enable), "accepted write left tx state wrong")
    `UARTRB_ASSERT(a_empty_read_zero, (out_valid && rx_was_empty) |-> (read_byte == '0), "empty read returned data")

endmodule

>>> bench/tb_top.sv
// self-checking bench for the uart ring buffer block: directed table, then random traffic
// depends on uartrb_pkg and uart_rx_tx_ring_buffers; results checked against typed golden values or a ring model
module tb_top
    import uartrb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = RING_DEPTH_DEF;

    // codes the block treats as no-ops
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI  = 3'd7;

    localparam int RANDOM_EVENTS = 570;

    typedef struct packed
    {
        logic              write_accepted;
        logic [BYTE_W-1:0] read_byte;
        logic              rx_was_empty;
        logic [BYTE_W-1:0] line_byte;
        logic              line_byte_valid;
        logic              tx_irq_enable;
        logic              tx_pending;
    } uart_result_t;

    typedef struct packed
    {
        logic [FUNC_W-1:0] code;
        logic [BYTE_W-1:0] data;
        logic              ferr;
        logic [7:0]        reps;
        logic              typed;
        uart_result_t      golden;
    } stim_row_t;

    typedef enum
    {
        MODE_FILL_TX,
        MODE_DRAIN_TX,
        MODE_LINE_RX,
        MODE_READ_RX,
        MODE_MIXED,
        MODE_FLUSH
    } traffic_mode_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_error;
    logic              out_valid;
    logic              out_stall;
    logic              write_accepted;
    logic [BYTE_W-1:0] read_byte;
    logic              rx_was_empty;
    logic [BYTE_W-1:0] line_byte;
    logic              line_byte_valid;
    logic              tx_irq_enable;
    logic              tx_pending;

    // ring model state
    logic [BYTE_W-1:0] rx_ring [DEPTH];
    logic [BYTE_W-1:0] tx_ring [DEPTH];
    int unsigned       rx_wr_idx;
    int unsigned       rx_rd_idx;
    int unsigned       tx_wr_idx;
    int unsigned       tx_rd_idx;
    logic              irq_en_model;

    uart_result_t      due_results [$];

    // run control and bookkeeping
    bit calm;
    bit sender_gaps_on;
    bit stall_bursts_on;
    int fail_count;
    int results_checked;
    int func_hits [8];
    int refused_writes;
    int empty_reads;
    int idle_tx_events;

    uart_rx_tx_ring_buffers #(.RING_DEPTH(DEPTH)) dut (.*);

    // directed table; golden values typed in only where they are obvious
    stim_row_t plan [] = '{
        '{FUNC_HOST_READ,  8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_TX_EMPTY,   8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_LINE_RX,    8'hFF, 1'b1, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_LINE_RX,    8'hFF, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_HOST_READ,  8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_LINE_RX,    8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_LINE_RX,    8'h80, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_FLUSH_RX,   8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_HOST_READ,  8'h5A, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_HOST_WRITE, 8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}},
        '{FUNC_HOST_WRITE, 8'hFF, 1'b0, 8'd1,  1'b1,
            '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}},
        '{FUNC_TX_EMPTY,   8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1}},
        '{FUNC_TX_EMPTY,   8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b0}},
        '{FUNC_TX_EMPTY,   8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_UNUSED_LO,  8'hFF, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_UNUSED_MID, 8'hAA, 1'b1, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_UNUSED_HI,  8'h55, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        // fill the transmit ring, then one write that must be refused
        '{FUNC_HOST_WRITE, 8'h10, 1'b0, 8'd15, 1'b0, '0},
        '{FUNC_HOST_WRITE, 8'h7E, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}},
        '{FUNC_TX_EMPTY,   8'h00, 1'b0, 8'd16, 1'b0, '0},
        // fill the receive ring, then one byte that must be dropped
        '{FUNC_LINE_RX,    8'h20, 1'b0, 8'd15, 1'b0, '0},
        '{FUNC_LINE_RX,    8'hC3, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_HOST_READ,  8'h00, 1'b0, 8'd8,  1'b0, '0},
        '{FUNC_FLUSH_RX,   8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{FUNC_HOST_READ,  8'h00, 1'b0, 8'd1,  1'b1,
            '{1'b0, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
        // receive ring restarts at slot zero after the flush
        '{FUNC_LINE_RX,    8'h3C, 1'b0, 8'd2,  1'b0, '0},
        '{FUNC_HOST_READ,  8'h00, 1'b0, 8'd3,  1'b0, '0}
    };

    // one event applied to the ring model; returns the result it must produce
    function automatic uart_result_t ring_model_step(
        input logic [FUNC_W-1:0] code,
        input logic [BYTE_W-1:0] data,
        input logic              ferr
    );
        uart_result_t r;
        int unsigned  nx;
        r = '0;
        case (code)
            FUNC_HOST_WRITE:
            begin
                nx = (tx_wr_idx + 1) % DEPTH;
                if (nx != tx_rd_idx)
                begin
                    tx_ring[tx_wr_idx] = data;
                    tx_wr_idx = nx;
                    r.write_accepted = 1'b1;
                    irq_en_model = 1'b1;
                end
            end
            FUNC_HOST_READ:
            begin
                if (rx_wr_idx == rx_rd_idx)
                    r.rx_was_empty = 1'b1;
                else
                begin
                    r.read_byte = rx_ring[rx_rd_idx];
                    rx_rd_idx = (rx_rd_idx + 1) % DEPTH;
                end
            end
            FUNC_LINE_RX:
            begin
                nx = (rx_wr_idx + 1) % DEPTH;
                if (!ferr && nx != rx_rd_idx)
                begin
                    rx_ring[rx_wr_idx] = data;
                    rx_wr_idx = nx;
                end
            end
            FUNC_TX_EMPTY:
            begin
                if (tx_wr_idx != tx_rd_idx)
                begin
                    r.line_byte = tx_ring[tx_rd_idx];
                    r.line_byte_valid = 1'b1;
                    tx_rd_idx = (tx_rd_idx + 1) % DEPTH;
                end
                else
                    irq_en_model = 1'b0;
            end
            FUNC_FLUSH_RX:
            begin
                rx_wr_idx = 0;
                rx_rd_idx = 0;
            end
            default:
            begin
            end
        endcase
        r.tx_irq_enable = irq_en_model;
        r.tx_pending = (tx_wr_idx != tx_rd_idx);
        return r;
    endfunction

    // present one event, wait for it to be taken, record what must come back
    task automatic issue_event(
        input logic [FUNC_W-1:0] code,
        input logic [BYTE_W-1:0] data,
        input logic              ferr,
        input logic              typed,
        input uart_result_t      golden
    );
        uart_result_t model_res;
        in_valid <= 1'b1;
        func <= code;
        data_byte <= data;
        frame_error <= ferr;
        do
            @(posedge clk);
        while (in_stall);
        model_res = ring_model_step(code, data, ferr);
        due_results.push_back(typed ? golden : model_res);
        func_hits[code]++;
        if (code == FUNC_HOST_WRITE && !model_res.write_accepted)
            refused_writes++;
        if (model_res.rx_was_empty)
            empty_reads++;
        if (code == FUNC_TX_EMPTY && !model_res.line_byte_valid)
            idle_tx_events++;
        // random sender gap
        if (!calm && sender_gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // stop sending until every outstanding result has been returned
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    // bursts of well-formed traffic with random content, plus noise
    task automatic run_traffic(input int total);
        int                sent;
        int                burst;
        int                roll;
        int                next_drain;
        traffic_mode_t     mode;
        logic [FUNC_W-1:0] code;
        logic              ferr;
        sent = 0;
        next_drain = 160;
        while (sent < total)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
                mode = MODE_FILL_TX;
            else if (roll < 40)
                mode = MODE_DRAIN_TX;
            else if (roll < 58)
                mode = MODE_LINE_RX;
            else if (roll < 76)
                mode = MODE_READ_RX;
            else if (roll < 96)
                mode = MODE_MIXED;
            else
                mode = MODE_FLUSH;
            burst = (mode == MODE_FLUSH) ? 1 : $urandom_range(1, 18);
            if (burst > total - sent)
                burst = total - sent;
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            stall_bursts_on = ($urandom_range(0, 3) != 0);
            if (total - sent <= 100)
                calm = 1'b1;
            repeat (burst)
            begin
                ferr = 1'b0;
                case (mode)
                    MODE_FILL_TX:  code = FUNC_HOST_WRITE;
                    MODE_DRAIN_TX: code = FUNC_TX_EMPTY;
                    MODE_LINE_RX:
                    begin
                        code = FUNC_LINE_RX;
                        ferr = ($urandom_range(0, 7) == 0);
                    end
                    MODE_READ_RX:  code = FUNC_HOST_READ;
                    MODE_FLUSH:    code = FUNC_FLUSH_RX;
                    default:
                    begin
                        code = FUNC_W'($urandom_range(0, 2**FUNC_W - 1));
                        ferr = 1'($urandom_range(0, 1));
                    end
                endcase
                issue_event(code, BYTE_W'($urandom_range(0, 255)), ferr, 1'b0, '0);
                sent++;
            end
            if (sent >= next_drain)
            begin
                hold_until_drained();
                next_drain += 160;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            fail_count++;
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stall bursts
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && stall_bursts_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each returned transaction with the oldest outstanding one
    always @(posedge clk)
    begin : result_check
        uart_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("result transaction with none outstanding");
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                results_checked++;
                check_field("write_accepted", BYTE_W'(want.write_accepted),
                            BYTE_W'(write_accepted));
                check_field("read_byte", want.read_byte, read_byte);
                check_field("rx_was_empty", BYTE_W'(want.rx_was_empty),
                            BYTE_W'(rx_was_empty));
                check_field("line_byte", want.line_byte, line_byte);
                check_field("line_byte_valid", BYTE_W'(want.line_byte_valid),
                            BYTE_W'(line_byte_valid));
                check_field("tx_irq_enable", BYTE_W'(want.tx_irq_enable),
                            BYTE_W'(tx_irq_enable));
                check_field("tx_pending", BYTE_W'(want.tx_pending),
                            BYTE_W'(tx_pending));
            end
        end
    end

    // run limit
    initial
    begin
        #200_000;
        $display("*** FAILED ***");
        $finish;
    end

    // main sequence
    initial
    begin
        in_valid = 1'b0;
        func = FUNC_HOST_WRITE;
        data_byte = '0;
        frame_error = 1'b0;
        rst_n = 1'b0;
        calm = 1'b0;
        sender_gaps_on = 1'b1;
        stall_bursts_on = 1'b1;
        rx_wr_idx = 0;
        rx_rd_idx = 0;
        tx_wr_idx = 0;
        tx_rd_idx = 0;
        irq_en_model = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            for (int k = 0; k < plan[i].reps; k++)
                issue_event(plan[i].code, BYTE_W'(plan[i].data + k), plan[i].ferr,
                            plan[i].typed, plan[i].golden);
        end
        hold_until_drained();

        run_traffic(RANDOM_EVENTS);

        // drain and let the pipeline settle
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
        repeat (6) @(posedge clk);

        $display("covered %0d writes, %0d reads, %0d line bytes, %0d tx-empty, %0d flushes",
                 func_hits[FUNC_HOST_WRITE], func_hits[FUNC_HOST_READ],
                 func_hits[FUNC_LINE_RX], func_hits[FUNC_TX_EMPTY],
                 func_hits[FUNC_FLUSH_RX]);
        $display("%0d no-ops, %0d results checked; %0d refused writes, %0d empty reads, %0d idle tx",
                 func_hits[FUNC_UNUSED_LO] + func_hits[FUNC_UNUSED_MID]
                 + func_hits[FUNC_UNUSED_HI],
                 results_checked, refused_writes, empty_reads, idle_tx_events);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
